/* design/stc_pkg.sv */
// Shared types, widths and constants of the spring torque datapath.
// Used by stc_cordic, stc_sqrt, stc_div and spring_torque_from_angle_core.
package stc_pkg;

  localparam int ZW       = 35;  // CORDIC angle, Q30 with headroom
  localparam int XW       = 34;  // CORDIC x/y, Q30 with headroom
  localparam int AtanMax  = 24;
  localparam int RootInW  = 20;  // root argument R, Q24
  localparam int RootW    = 22;  // A = floor(sqrt(R * 2^24))
  localparam int DmagW    = 16;  // |precompression - rest_offset|
  localparam int QuoW     = 32;  // |ratio|, Q24
  localparam int TorqueW  = 24;

  localparam logic signed [XW-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [ZW-1:0] HalfPi     = 35'sh06487ED51;
  localparam logic signed [ZW-1:0] Pi         = 35'sh0C90FDAA2;

  localparam logic signed [TorqueW-1:0] TorqueMax = 24'sh7FFFFF;
  localparam logic signed [TorqueW-1:0] TorqueMin = 24'sh800000;

  // configuration register indexes
  localparam logic [2:0] CfgTorqueGain = 3'd0;
  localparam logic [2:0] CfgRestOffset = 3'd1;
  localparam logic [2:0] CfgGeomBase   = 3'd2;
  localparam logic [2:0] CfgGeomCosW   = 3'd3;

  typedef struct packed {
    logic signed [15:0] pre;
    logic               flip;
  } stc_trig_side_t;

  typedef struct packed {
    logic signed [XW-1:0] sin;
    logic [DmagW-1:0]     dmag;
    logic                 neg;
    logic                 bad;
  } stc_side_t;

  // arctangent of 2^-idx, Q30, truncated
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'h3243F6A8;
      1:  v = 30'h1DAC6705;
      2:  v = 30'h0FADBAFC;
      3:  v = 30'h07F56EA6;
      4:  v = 30'h03FEAB76;
      5:  v = 30'h01FFD55B;
      6:  v = 30'h00FFFAAA;
      7:  v = 30'h007FFF55;
      8:  v = 30'h003FFFEA;
      9:  v = 30'h001FFFFD;
      10: v = 30'h000FFFFF;
      11: v = 30'h0007FFFF;
      12: v = 30'h0003FFFF;
      13: v = 30'h0001FFFF;
      14: v = 30'h0000FFFF;
      15: v = 30'h00007FFF;
      16: v = 30'h00003FFF;
      17: v = 30'h00001FFF;
      18: v = 30'h00000FFF;
      19: v = 30'h000007FF;
      20: v = 30'h000003FF;
      21: v = 30'h000001FF;
      22: v = 30'h000000FF;
      23: v = 30'h0000007F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

/* design/spring_torque_from_angle_core.sv */
// Spring torque core: top level with config registers and the pipeline glue.
// Depends on stc_pkg, stc_cordic, stc_sqrt and stc_div.

// One sample enters on any cycle (busy stays low) and its torque appears on a
// one-cycle result_valid_o strobe, in input order. The pipeline consists of
// the CORDIC stages (one per iteration), 22 square-root stages, 44 divider
// stages and 7 stages of angle reduction, multiplies and clipping; throughput
// is one sample per cycle. The receiver cannot stall. Registers are written
// through the cfg channel (always ready) and must only change while no sample
// is in flight. A non-positive root argument gives torque 0 with the flag set.
module spring_torque_from_angle_core #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] lever_angle_i,
  input  logic signed [15:0] spring_precompression_i,
  output logic               result_valid_o,
  output logic signed [23:0] joint_torque_o,
  output logic               torque_saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i
);

  localparam int NumIter = (TRIG_ITERATIONS > stc_pkg::AtanMax) ? stc_pkg::AtanMax
                                                                : TRIG_ITERATIONS;
  localparam int Latency = NumIter + 73;
  localparam int XW = stc_pkg::XW;
  localparam int ZW = stc_pkg::ZW;

  // ---------------- configuration registers
  logic [15:0] gain_q;
  logic [14:0] rest_q;
  logic [17:0] base_q;
  logic [17:0] cosw_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 16'd23744;
      rest_q <= 15'd15729;
      base_q <= 18'd62495;
      cosw_q <= 18'd58720;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        stc_pkg::CfgTorqueGain: gain_q <= cfg_data_i[15:0];
        stc_pkg::CfgRestOffset: rest_q <= cfg_data_i[14:0];
        stc_pkg::CfgGeomBase:   base_q <= cfg_data_i;
        stc_pkg::CfgGeomCosW:   cosw_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------- stage 0: scale angle to Q30 and fold into +-pi/2
  logic                    in_xfer;
  logic signed [ZW-1:0]    z_full;
  logic                    v0_q;
  logic signed [ZW-1:0]    z0_q;
  stc_pkg::stc_trig_side_t t0_q;

  assign in_xfer = start && !busy;
  assign z_full  = $signed({{(ZW-33){lever_angle_i[15]}}, lever_angle_i, 17'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q.pre <= spring_precompression_i;
    if (z_full > stc_pkg::HalfPi) begin
      z0_q      <= z_full - stc_pkg::Pi;
      t0_q.flip <= 1'b1;
    end else if (z_full < -stc_pkg::HalfPi) begin
      z0_q      <= z_full + stc_pkg::Pi;
      t0_q.flip <= 1'b1;
    end else begin
      z0_q      <= z_full;
      t0_q.flip <= 1'b0;
    end
  end

  // ---------------- CORDIC sine/cosine
  logic                    vc;
  logic signed [XW-1:0]    cos_c, sin_c;
  stc_pkg::stc_trig_side_t tc;

  stc_cordic #(.NumIter(NumIter)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .z_i     (z0_q),
    .side_i  (t0_q),
    .valid_o (vc),
    .cos_o   (cos_c),
    .sin_o   (sin_c),
    .side_o  (tc)
  );

  // ---------------- M1: undo the fold
  logic                 v1_q;
  logic signed [XW-1:0] cos1_q, sin1_q;
  logic signed [15:0]   pre1_q;

  // ---------------- M2: cosine weight product
  logic                 v2_q;
  logic signed [52:0]   cprod2_q;
  logic signed [XW-1:0] sin2_q;
  logic signed [15:0]   pre2_q;

  // ---------------- M3: root argument and spring offset
  logic                 v3_q;
  logic [stc_pkg::RootInW-1:0] r3_q;
  stc_pkg::stc_side_t   s3_q;
  logic signed [23:0]   r_val;
  logic signed [16:0]   d_val;

  // floor shift of the signed product keeps its sign
  assign r_val = $signed({6'b0, base_q}) - $signed(cprod2_q[52:30]);
  assign d_val = $signed({pre2_q[15], pre2_q}) - $signed({2'b0, rest_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= vc;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cos1_q   <= tc.flip ? -cos_c : cos_c;
    sin1_q   <= tc.flip ? -sin_c : sin_c;
    pre1_q   <= tc.pre;
    cprod2_q <= 53'($signed({1'b0, cosw_q}) * cos1_q);
    sin2_q   <= sin1_q;
    pre2_q   <= pre1_q;
    // hold the root argument at zero when it is not positive; result is forced
    r3_q     <= (r_val > 0) ? r_val[stc_pkg::RootInW-1:0] : '0;
    s3_q.bad <= !(r_val > 0);
    s3_q.sin <= sin2_q;
    s3_q.neg <= d_val[16];
    s3_q.dmag <= d_val[16] ? 16'(-d_val) : d_val[15:0];
  end

  // ---------------- square root and division
  logic                      vs, vd;
  logic [stc_pkg::RootW-1:0] root_s;
  stc_pkg::stc_side_t        ss, sd;
  logic [stc_pkg::QuoW-1:0]  quo_d;

  stc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .r_i     (r3_q),
    .side_i  (s3_q),
    .valid_o (vs),
    .root_o  (root_s),
    .side_o  (ss)
  );

  stc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vs),
    .den_i   (root_s),
    .side_i  (ss),
    .valid_o (vd),
    .quo_o   (quo_d),
    .side_o  (sd)
  );

  // ---------------- G1: gain times (1 + ratio), G2: times sine, G3: clip, or zero on a bad root argument
  logic signed [32:0]   ratio;
  logic signed [33:0]   one_plus;
  logic                 vg1_q, vg2_q, vo_q;
  logic signed [50:0]   gprod_q;
  logic signed [XW-1:0] sin_g1_q;
  logic                 bad_g1_q, bad_g2_q;
  logic signed [64:0]   tprod_q;
  logic signed [32:0]   t_val;
  logic signed [23:0]   torque_q;
  logic                 sat_q;

  assign ratio    = sd.neg ? -$signed({1'b0, quo_d}) : $signed({1'b0, quo_d});
  assign one_plus = $signed(34'sd16777216) + 34'(ratio);
  assign t_val    = tprod_q[64:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg1_q <= 1'b0;
      vg2_q <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      vg1_q <= vd;
      vg2_q <= vg1_q;
      vo_q  <= vg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gprod_q  <= 51'($signed({1'b0, gain_q}) * one_plus);
    sin_g1_q <= sd.sin;
    bad_g1_q <= sd.bad;
    tprod_q  <= 65'($signed(gprod_q[50:20]) * sin_g1_q);
    bad_g2_q <= bad_g1_q;
    if (bad_g2_q) begin
      torque_q <= '0;
      sat_q    <= 1'b1;
    end else if (t_val > 33'(stc_pkg::TorqueMax)) begin
      torque_q <= stc_pkg::TorqueMax;
      sat_q    <= 1'b1;
    end else if (t_val < 33'(stc_pkg::TorqueMin)) begin
      torque_q <= stc_pkg::TorqueMin;
      sat_q    <= 1'b1;
    end else begin
      torque_q <= t_val[23:0];
      sat_q    <= 1'b0;
    end
  end

  assign result_valid_o     = vo_q;
  assign joint_torque_o     = torque_q;
  assign torque_saturated_o = sat_q;

  // ---------------- assertions
  a_latency_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##Latency result_valid_o)
    else $error("result strobe missing after accepted transfer");

  a_latency_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |-> ##Latency !result_valid_o)
    else $error("result strobe without accepted transfer");

  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && torque_saturated_o) |->
      (joint_torque_o == 24'sd0 || joint_torque_o == stc_pkg::TorqueMax ||
       joint_torque_o == stc_pkg::TorqueMin))
    else $error("saturation flag with unclipped torque");

endmodule

/* design/stc_cordic.sv */
// Pipelined CORDIC rotation, one iteration per register stage.
// Depends on stc_pkg for widths, the arctangent table and the side struct.
module stc_cordic #(
  parameter int NumIter = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [stc_pkg::ZW-1:0] z_i,
  input  stc_pkg::stc_trig_side_t      side_i,
  output logic                         valid_o,
  output logic signed [stc_pkg::XW-1:0] cos_o,
  output logic signed [stc_pkg::XW-1:0] sin_o,
  output stc_pkg::stc_trig_side_t      side_o
);

  logic                          valid_q [NumIter];
  logic signed [stc_pkg::XW-1:0] x_q     [NumIter];
  logic signed [stc_pkg::XW-1:0] y_q     [NumIter];
  logic signed [stc_pkg::ZW-1:0] z_q     [NumIter];
  stc_pkg::stc_trig_side_t       side_q  [NumIter];

  for (genvar i = 0; i < NumIter; i++) begin : g_iter
    logic                          v_in;
    logic signed [stc_pkg::XW-1:0] x_in, y_in, xs, ys;
    logic signed [stc_pkg::ZW-1:0] z_in, at;
    stc_pkg::stc_trig_side_t       s_in;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = stc_pkg::CordicGain;
      assign y_in = '0;
      assign z_in = z_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign s_in = side_q[i-1];
    end

    assign xs = x_in >>> i;
    assign ys = y_in >>> i;
    assign at = $signed({{(stc_pkg::ZW-30){1'b0}}, stc_pkg::atan_q30(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i] <= s_in;
      if (!z_in[stc_pkg::ZW-1]) begin
        x_q[i] <= x_in - ys;
        y_q[i] <= y_in + xs;
        z_q[i] <= z_in - at;
      end else begin
        x_q[i] <= x_in + ys;
        y_q[i] <= y_in - xs;
        z_q[i] <= z_in + at;
      end
    end
  end

  assign valid_o = valid_q[NumIter-1];
  assign cos_o   = x_q[NumIter-1];
  assign sin_o   = y_q[NumIter-1];
  assign side_o  = side_q[NumIter-1];

endmodule

/* design/stc_sqrt.sv */
// Pipelined integer square root of R * 2^24, one result bit per stage.
// Depends on stc_pkg for widths and the side struct.
module stc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [stc_pkg::RootInW-1:0] r_i,
  input  stc_pkg::stc_side_t          side_i,
  output logic                        valid_o,
  output logic [stc_pkg::RootW-1:0]   root_o,
  output stc_pkg::stc_side_t          side_o
);

  localparam int Steps = stc_pkg::RootW;
  localparam int VW    = 2 * Steps;       // width of R * 2^24
  localparam int LowW  = VW - stc_pkg::RootInW;
  localparam int RemW  = stc_pkg::RootW + 1;

  logic                        valid_q [Steps];
  logic [stc_pkg::RootInW-1:0] r_q     [Steps];
  logic [stc_pkg::RootW-1:0]   root_q  [Steps];
  logic [RemW-1:0]             rem_q   [Steps];
  stc_pkg::stc_side_t          side_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam int Hi = VW - 1 - 2 * k;
    logic                        v_in;
    logic [stc_pkg::RootInW-1:0] r_in;
    logic [stc_pkg::RootW-1:0]   root_in;
    logic [RemW-1:0]             rem_in;
    stc_pkg::stc_side_t          s_in;
    logic [1:0]                  pair;
    logic [RemW+1:0]             rem_n, trial;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign r_in    = r_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign r_in    = r_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign s_in    = side_q[k-1];
    end

    if (Hi - 1 >= LowW) begin : g_pair
      assign pair = r_in[Hi-LowW -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign rem_n = {rem_in, pair};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[k]    <= r_in;
      side_q[k] <= s_in;
      if (rem_n >= trial) begin
        rem_q[k]  <= RemW'(rem_n - trial);
        root_q[k] <= {root_in[stc_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= RemW'(rem_n);
        root_q[k] <= {root_in[stc_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

/* design/stc_div.sv */
// Pipelined restoring divider: (dmag * 2^28) / root, one quotient bit per stage.
// Depends on stc_pkg for widths and the side struct.
module stc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [stc_pkg::RootW-1:0] den_i,
  input  stc_pkg::stc_side_t        side_i,
  output logic                      valid_o,
  output logic [stc_pkg::QuoW-1:0]  quo_o,
  output stc_pkg::stc_side_t        side_o
);

  localparam int FracW = 28;
  localparam int Steps = stc_pkg::DmagW + FracW;
  localparam int RemW  = stc_pkg::RootW;

  logic                      valid_q [Steps];
  logic [stc_pkg::RootW-1:0] den_q   [Steps];
  logic [RemW-1:0]           rem_q   [Steps];
  logic [stc_pkg::QuoW-1:0]  quo_q   [Steps];
  stc_pkg::stc_side_t        side_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                      v_in, nbit;
    logic [stc_pkg::RootW-1:0] den_in;
    logic [RemW-1:0]           rem_in;
    logic [stc_pkg::QuoW-1:0]  quo_in;
    stc_pkg::stc_side_t        s_in;
    logic [RemW:0]             rem_n;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign s_in   = side_q[k-1];
    end

    if (k < stc_pkg::DmagW) begin : g_num
      assign nbit = s_in.dmag[stc_pkg::DmagW-1-k];
    end else begin : g_frac
      assign nbit = 1'b0;
    end

    assign rem_n = {rem_in, nbit};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[k]  <= den_in;
      side_q[k] <= s_in;
      if (rem_n >= {1'b0, den_in}) begin
        rem_q[k] <= RemW'(rem_n - {1'b0, den_in});
        quo_q[k] <= {quo_in[stc_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_q[k] <= RemW'(rem_n);
        quo_q[k] <= {quo_in[stc_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

/* tb/tb_spring_torque_from_angle_core.sv */
// Self-checking testbench for spring_torque_from_angle_core: random and directed samples
// are checked against a built-in fixed-point torque predictor.
// Depends on stc_pkg for the register indexes and the core itself.
module tb_spring_torque_from_angle_core;

  localparam int TrigIter = 16;
  localparam int DrainCycles = TrigIter + 73 + 20;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] pre;
  } sample_t;

  typedef struct {
    logic signed [23:0] torque;
    logic               sat;
  } torque_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [15:0] lever_angle_i;
  logic signed [15:0] spring_precompression_i;
  logic               result_valid_o;
  logic signed [23:0] joint_torque_o;
  logic               torque_saturated_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [17:0]        cfg_data_i;

  // predictor copy of the configuration registers
  logic [15:0] gain_q;
  logic [14:0] rest_q;
  logic [17:0] base_q;
  logic [17:0] cosw_q;

  sample_t pending_samples[$];
  torque_t expected_torques[$];
  int      mismatches;
  bit      took;        // the driven sample was taken at the last rising edge
  bit      steady;      // no idling while set
  longint  atan_tab[24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  spring_torque_from_angle_core #(
    .TRIG_ITERATIONS(TrigIter)
  ) i_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .start                   (start),
    .busy                    (busy),
    .lever_angle_i           (lever_angle_i),
    .spring_precompression_i (spring_precompression_i),
    .result_valid_o          (result_valid_o),
    .joint_torque_o          (joint_torque_o),
    .torque_saturated_o      (torque_saturated_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // floor(sqrt(v)), bitwise
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Expected torque of one sample under the current register copy.
  function automatic torque_t torque_of(input sample_t smp);
    torque_t res;
    longint  z, x, y, xs, ys, r, a, d, ratio, p, t;
    longint unsigned mag;
    bit      flip;
    int      n;
    n = (TrigIter > 24) ? 24 : TrigIter;
    z = longint'(smp.angle) * 131072;
    x = longint'(stc_pkg::CordicGain);
    y = 0;
    flip = 1'b0;
    // fold the angle into [-pi/2, pi/2]; a folded angle negates the outputs
    if (z > longint'(stc_pkg::HalfPi)) begin
      z -= longint'(stc_pkg::Pi);
      flip = 1'b1;
    end else if (z < -longint'(stc_pkg::HalfPi)) begin
      z += longint'(stc_pkg::Pi);
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_tab[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r = longint'(base_q) - ((longint'(cosw_q) * x) >>> 30);
    // root argument not positive: zero torque, flag set
    if (r <= 0) begin
      res.torque = '0;
      res.sat = 1'b1;
      return res;
    end
    a = longint'(root_floor(longint'(unsigned'(r)) << 24));
    d = longint'(smp.pre) - longint'(rest_q);
    mag = (longint'(unsigned'(d < 0 ? -d : d)) << 28) / longint'(unsigned'(a));
    ratio = (d < 0) ? -longint'(mag) : longint'(mag);
    p = (longint'(gain_q) * ((64'sd1 <<< 24) + ratio)) >>> 20;
    t = (p * y) >>> 32;
    res.sat = 1'b0;
    if (t > 8388607) begin
      t = 8388607;
      res.sat = 1'b1;
    end else if (t < -8388608) begin
      t = -8388608;
      res.sat = 1'b1;
    end
    res.torque = t[23:0];
    return res;
  endfunction

  // Monitor: predict on each accepted sample, check each result strobe.
  always @(posedge clk_i) begin
    torque_t want;
    took = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_torques.push_back(
          torque_of(sample_t'{lever_angle_i, spring_precompression_i}));
        took = 1'b1;
      end
      if (result_valid_o) begin
        if (expected_torques.size() == 0) begin
          $error("result with nothing expected: joint_torque %0d", joint_torque_o);
          mismatches++;
        end else begin
          want = expected_torques.pop_front();
          if (joint_torque_o !== want.torque) begin
            $error("joint_torque expected %0d actual %0d", want.torque, joint_torque_o);
            mismatches++;
          end
          if (torque_saturated_o !== want.sat) begin
            $error("torque_saturated expected %0d actual %0d", want.sat,
                   torque_saturated_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Driver: hold a sample until taken, then advance or idle.
  always @(negedge clk_i) begin
    sample_t nxt;
    if (rst_ni && (!start || took)) begin
      if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
        nxt = pending_samples.pop_front();
        lever_angle_i <= nxt.angle;
        spring_precompression_i <= nxt.pre;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Write one register over the config channel and mirror it.
  task automatic write_reg(input logic [2:0] idx, input logic [17:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      stc_pkg::CfgTorqueGain: gain_q = data[15:0];
      stc_pkg::CfgRestOffset: rest_q = data[14:0];
      stc_pkg::CfgGeomBase:   base_q = data;
      stc_pkg::CfgGeomCosW:   cosw_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every queued sample is taken and every result is back.
  task automatic drain();
    while (pending_samples.size() != 0 || start || expected_torques.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_angle();
    // mostly within +-pi, sometimes the whole field
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($urandom_range(51472) - 25736);
  endfunction

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_samples.push_back('{rand_angle(), 16'($urandom)});
  endtask

  initial begin
    logic signed [15:0] angles[12] = '{0, 1, -1, 12868, -12868, 12869, -12869,
                                       25736, -25736, 32767, -32768, 6434};
    rst_ni = 1'b0;
    start = 1'b0;
    lever_angle_i = '0;
    spring_precompression_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = stc_pkg::CfgTorqueGain;
    cfg_data_i = '0;
    mismatches = 0;
    steady = 1'b0;
    gain_q = 16'd23744;
    rest_q = 15'd15729;
    base_q = 18'd62495;
    cosw_q = 18'd58720;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: angle corners, folding boundaries, precompression extremes
    foreach (angles[i])
      pending_samples.push_back('{angles[i], (i % 2) ? 16'sh7FFF : 16'sh8000});
    pending_samples.push_back('{16'sd8000, 16'sd15729});
    pending_samples.push_back('{16'sd8000, 16'sd0});
    drain();

    // extremes: base zero, so the root argument is not positive unless the cosine is negative; gain zero
    write_reg(stc_pkg::CfgGeomBase, 18'd0);
    write_reg(stc_pkg::CfgTorqueGain, 18'd0);
    write_reg(3'd5, 18'h3FFFF);  // out of range index, must be ignored
    queue_random(40);
    drain();

    // large gain, small root, max rest offset: forces clipping
    write_reg(stc_pkg::CfgTorqueGain, 18'h0FFFF);
    write_reg(stc_pkg::CfgRestOffset, 18'h07FFF);
    write_reg(stc_pkg::CfgGeomBase, 18'd1);
    write_reg(stc_pkg::CfgGeomCosW, 18'd0);
    steady = 1'b1;
    queue_random(250);
    drain();
    steady = 1'b0;

    write_reg(stc_pkg::CfgRestOffset, 18'd0);
    write_reg(stc_pkg::CfgGeomBase, 18'h3FFFF);
    write_reg(stc_pkg::CfgGeomCosW, 18'h3FFFF);
    write_reg(3'd7, 18'd0);
    queue_random(300);
    drain();

    // back to nominal geometry
    write_reg(stc_pkg::CfgTorqueGain, 18'd23744);
    write_reg(stc_pkg::CfgRestOffset, 18'd15729);
    write_reg(stc_pkg::CfgGeomBase, 18'd62495);
    write_reg(stc_pkg::CfgGeomCosW, 18'd58720);
    queue_random(400);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(stc_pkg::CfgTorqueGain, 18'($urandom));
      write_reg(stc_pkg::CfgRestOffset, 18'($urandom));
      write_reg(stc_pkg::CfgGeomBase, 18'($urandom));
      write_reg(stc_pkg::CfgGeomCosW, 18'($urandom));
      queue_random(210);
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
